// ===== sv/sensor_raw_compensation_assert.svh =====
// ----------------------------------------------------------------------------
// sensor_raw_compensation_assert.svh
// Assertion macros for the checker of the compensation block
// ----------------------------------------------------------------------------
`ifndef SENSOR_RAW_COMPENSATION_ASSERT_SVH
`define SENSOR_RAW_COMPENSATION_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define SRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("src check failed: same-cycle implication");

// next-cycle implication, sampled on clk, off during rst
`define SRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("src check failed: next-cycle implication");

`endif

// ===== sv/src_pkg.sv =====
// ----------------------------------------------------------------------------
// src_pkg
// Widths and calibration register indexes shared by the compensation block
// ----------------------------------------------------------------------------
package src_pkg;

  // pressure dividend is 64-bit two's complement
  localparam int unsigned NUM_W = 64;
  // divisor is a 64-bit value shifted right by 33, so 31 bits signed
  localparam int unsigned DEN_W = 31;

  // calibration register indexes on the cfg channel
  typedef enum logic [2:0] {
    CAL_TEMP    = 3'd0,
    CAL_PRESS_A = 3'd1,
    CAL_PRESS_B = 3'd2,
    CAL_MIXED   = 3'd3,
    CAL_HUM     = 3'd4
  } cal_idx_t;

endpackage

// ===== sv/src_div.sv =====
// ----------------------------------------------------------------------------
// src_div
// Pipelined signed division, truncating toward zero, with side data
// ----------------------------------------------------------------------------
module src_div
  import src_pkg::*;
#(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  logic [NUM_W-1:0]  numer,
  input  logic [DEN_W-1:0]  denom,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_vld,
  output logic [NUM_W-1:0]  quot,
  output logic [SIDE_W-1:0] side_out
);

  localparam int unsigned STEPS = 2;
  localparam int unsigned NSTG  = NUM_W / STEPS;

  typedef struct packed {
    logic              neg;
    logic [DEN_W-1:0]  dmag;
    logic [DEN_W-1:0]  rem;
    logic [NUM_W-1:0]  nq;
    logic [SIDE_W-1:0] side;
  } div_stg_t;

  logic [NSTG:0] vld;
  div_stg_t      stg [NSTG+1];

  // magnitudes and result sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
    if (en) begin
      stg[0].neg  <= numer[NUM_W-1] ^ denom[DEN_W-1];
      stg[0].nq   <= numer[NUM_W-1] ? (NUM_W'(0) - numer) : numer;
      stg[0].dmag <= denom[DEN_W-1] ? (DEN_W'(0) - denom) : denom;
      stg[0].rem  <= '0;
      stg[0].side <= side_in;
    end
  end

  // restoring steps, quotient bits shift in behind the dividend
  for (genvar k = 0; k < NSTG; k++) begin : g_stage
    div_stg_t        nxt;
    logic [DEN_W:0]  rem2;
    logic            ge;

    always_comb begin
      nxt  = stg[k];
      rem2 = '0;
      ge   = 1'b0;
      for (int i = 0; i < STEPS; i++) begin
        rem2    = {nxt.rem, nxt.nq[NUM_W-1]};
        ge      = (rem2 >= {1'b0, nxt.dmag});
        nxt.nq  = {nxt.nq[NUM_W-2:0], ge};
        nxt.rem = ge ? DEN_W'(rem2 - {1'b0, nxt.dmag}) : rem2[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        stg[k+1] <= nxt;
      end
    end
  end

  // apply sign
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= vld[NSTG];
    end
    if (en) begin
      quot     <= stg[NSTG].neg ? (NUM_W'(0) - stg[NSTG].nq) : stg[NSTG].nq;
      side_out <= stg[NSTG].side;
    end
  end

endmodule

// ===== sv/sensor_raw_compensation.sv =====
// ----------------------------------------------------------------------------
// sensor_raw_compensation
// Integer compensation of one pressure / temperature / humidity burst
// ----------------------------------------------------------------------------
//
//  channel   handshake                  payload
//  -------   -------------------------  -----------------------------------------
//  meas      meas_valid / meas_ready    press_*, temp_*, hum_* raw bytes
//  result    result_valid/result_ready  temperature_centi, pressure_q24_8,
//                                       pressure_invalid, humidity_q22_10
//  cfg       cfg_valid / cfg_ready      cfg_index, cfg_data (calibration words)
//
//  one measurement transfer per cycle while the skid entry is free; 10 front stages,
//  34 in the divider (2 quotient bits per stage over the 64-bit dividend),
//  5 back stages and the result register
//  rst is synchronous; it clears all valid bits and the calibration words
//  a two-entry output buffer (result register plus skid) parts the sides;
//  when the skid holds a result every stage freezes, nothing is dropped
//  cfg_ready is always high; write calibration only while the block is idle
//
module sensor_raw_compensation
  import src_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // measurement channel
  input  logic               meas_valid,
  output logic               meas_ready,
  input  logic [7:0]         press_msb,
  input  logic [7:0]         press_lsb,
  input  logic [7:0]         press_xlsb,
  input  logic [7:0]         temp_msb,
  input  logic [7:0]         temp_lsb,
  input  logic [7:0]         temp_xlsb,
  input  logic [7:0]         hum_msb,
  input  logic [7:0]         hum_lsb,
  // result channel
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [31:0] temperature_centi,
  output logic [31:0]        pressure_q24_8,
  output logic               pressure_invalid,
  output logic [16:0]        humidity_q22_10,
  // calibration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam logic [31:0] HUM_CLAMP = 32'd419430400;
  localparam logic [16:0] HUM_MAX   = 17'd102400;
  localparam int unsigned SIDE_W    = 3 * 32 + 1;

  // 32 / 64-bit arithmetic shifts and wrapping products
  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned s);
    logic signed [31:0] xs;
    xs = x;
    return xs >>> s;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned s);
    logic signed [63:0] xs;
    xs = x;
    return xs >>> s;
  endfunction

  // low 64 bits of a times a small signed coefficient
  function automatic logic [63:0] mul_lo64(input logic [63:0] a,
                                           input logic signed [16:0] b);
    logic signed [80:0] prod;
    prod = $signed(a) * b;
    return prod[63:0];
  endfunction

  // --------------------------------------------------------------------------
  // calibration words
  // --------------------------------------------------------------------------
  logic [47:0] cal_t;
  logic [63:0] cal_pa;
  logic [63:0] cal_pb;
  logic [55:0] cal_mx;
  logic [23:0] cal_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t  <= '0;
      cal_pa <= '0;
      cal_pb <= '0;
      cal_mx <= '0;
      cal_h  <= '0;
    end else if (cfg_valid) begin
      unique case (cal_idx_t'(cfg_index))
        CAL_TEMP:    cal_t  <= cfg_data[47:0];
        CAL_PRESS_A: cal_pa <= cfg_data;
        CAL_PRESS_B: cal_pb <= cfg_data;
        CAL_MIXED:   cal_mx <= cfg_data[55:0];
        CAL_HUM:     cal_h  <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  // coefficient fields
  logic [15:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic [7:0]  h1, h3, h6;
  logic [11:0] h4, h5;
  logic [31:0] t2_32, t3_32, h2_32, h5_32, h6_32, p7_32;

  assign t1 = cal_t[15:0];
  assign t2 = cal_t[31:16];
  assign t3 = cal_t[47:32];
  assign p1 = cal_pa[15:0];
  assign p2 = cal_pa[31:16];
  assign p3 = cal_pa[47:32];
  assign p4 = cal_pa[63:48];
  assign p5 = cal_pb[15:0];
  assign p6 = cal_pb[31:16];
  assign p7 = cal_pb[47:32];
  assign p8 = cal_pb[63:48];
  assign p9 = cal_mx[15:0];
  assign h1 = cal_mx[23:16];
  assign h2 = cal_mx[39:24];
  assign h3 = cal_mx[47:40];
  assign h6 = cal_mx[55:48];
  assign h4 = cal_h[11:0];
  assign h5 = cal_h[23:12];

  assign t2_32 = {{16{t2[15]}}, t2};
  assign t3_32 = {{16{t3[15]}}, t3};
  assign h2_32 = {{16{h2[15]}}, h2};
  assign h5_32 = {{20{h5[11]}}, h5};
  assign h6_32 = {{24{h6[7]}}, h6};
  assign p7_32 = {{16{p7[15]}}, p7};

  // --------------------------------------------------------------------------
  // pipeline control: every stage moves while the skid entry is free
  // --------------------------------------------------------------------------
  logic        adv;
  logic        skid_vld;
  logic [10:1] s_vld;
  logic [5:1]  d_vld;
  logic        div_vld;

  assign adv        = !skid_vld;
  assign meas_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= '0;
      d_vld <= '0;
    end else if (adv) begin
      s_vld <= {s_vld[9:1], meas_valid};
      d_vld <= {d_vld[4:1], div_vld};
    end
  end

  // --------------------------------------------------------------------------
  // front stages: temperature, fine term, pressure divisor and dividend,
  // first half of humidity
  // --------------------------------------------------------------------------
  logic [31:0] s1_a, s1_b, s2_v1raw, s2_bb, s3_v1, s3_v2raw, s4_tfine;
  logic [19:0] s1_adcp, s2_adcp, s3_adcp, s4_adcp, s5_adcp, s6_adcp, s7_adcp, s8_adcp;
  logic [15:0] s1_adch, s2_adch, s3_adch, s4_adch, s5_adch, s6_adch;
  logic [31:0] s5_temp, s6_temp, s7_temp, s8_temp, s9_temp, s10_temp;
  logic [32:0] s5_w1;
  logic [31:0] s5_hx;
  logic [63:0] s6_sq;
  logic [48:0] s6_w1p5, s6_w1p2, s7_w1p5, s7_w1p2;
  logic [31:0] s6_h5x, s6_hx6, s6_hx3;
  logic [63:0] s7_w2a, s7_sq3, s8_w2, s8_vv, s9_pw1, s9_pnum, s10_numr;
  logic [31:0] s7_e1, s7_e2, s7_e3, s8_e1, s9_e1, s10_e1;
  logic [31:0] s8_e4raw, s9_e4, s10_e5raw;
  logic [30:0] s10_den;

  logic signed [65:0] sq_full;
  logic signed [48:0] w1p5_full, w1p2_full;
  logic [20:0]        p_delta;

  always_comb begin
    sq_full   = $signed(s5_w1) * $signed(s5_w1);
    w1p5_full = $signed(s5_w1) * $signed(p5);
    w1p2_full = $signed(s5_w1) * $signed(p2);
    p_delta   = 21'd1048576 - {1'b0, s8_adcp};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: unpack, offsets against T1
      s1_a    <= {15'd0, temp_msb, temp_lsb, temp_xlsb[7]} - {15'd0, t1, 1'b0};
      s1_b    <= {16'd0, temp_msb, temp_lsb} - {16'd0, t1};
      s1_adcp <= {press_msb, press_lsb, press_xlsb[7:4]};
      s1_adch <= {hum_msb, hum_lsb};
      // stage 2
      s2_v1raw <= s1_a * t2_32;
      s2_bb    <= s1_b * s1_b;
      s2_adcp  <= s1_adcp;
      s2_adch  <= s1_adch;
      // stage 3
      s3_v1    <= asr32(s2_v1raw, 11);
      s3_v2raw <= asr32(s2_bb, 12) * t3_32;
      s3_adcp  <= s2_adcp;
      s3_adch  <= s2_adch;
      // stage 4: fine temperature
      s4_tfine <= s3_v1 + asr32(s3_v2raw, 14);
      s4_adcp  <= s3_adcp;
      s4_adch  <= s3_adch;
      // stage 5: temperature result, pressure and humidity offsets
      s5_temp <= asr32(s4_tfine * 32'd5 + 32'd128, 8);
      s5_w1   <= {s4_tfine[31], s4_tfine} - 33'd128000;
      s5_hx   <= s4_tfine - 32'd76800;
      s5_adcp <= s4_adcp;
      s5_adch <= s4_adch;
      // stage 6: square of the offset, first humidity products
      s6_sq   <= sq_full[63:0];
      s6_w1p5 <= w1p5_full;
      s6_w1p2 <= w1p2_full;
      s6_h5x  <= h5_32 * s5_hx;
      s6_hx6  <= s5_hx * h6_32;
      s6_hx3  <= s5_hx * {24'd0, h3};
      s6_temp <= s5_temp;
      s6_adcp <= s5_adcp;
      s6_adch <= s5_adch;
      // stage 7
      s7_w2a  <= mul_lo64(s6_sq, {p6[15], p6});
      s7_sq3  <= mul_lo64(s6_sq, {p3[15], p3});
      s7_w1p5 <= s6_w1p5;
      s7_w1p2 <= s6_w1p2;
      s7_e1   <= asr32({2'd0, s6_adch, 14'd0} - ({h4, 20'd0} + s6_h5x) + 32'd16384, 15);
      s7_e2   <= asr32(s6_hx6, 10);
      s7_e3   <= asr32(s6_hx3, 11) + 32'd32768;
      s7_temp <= s6_temp;
      s7_adcp <= s6_adcp;
      // stage 8: dividend offset and divisor base
      s8_w2    <= s7_w2a + ({{15{s7_w1p5[48]}}, s7_w1p5} << 17)
                  + ({{48{p4[15]}}, p4} << 35);
      s8_vv    <= 64'h0000_8000_0000_0000 + asr64(s7_sq3, 8)
                  + ({{15{s7_w1p2[48]}}, s7_w1p2} << 12);
      s8_e4raw <= s7_e2 * s7_e3;
      s8_e1    <= s7_e1;
      s8_temp  <= s7_temp;
      s8_adcp  <= s7_adcp;
      // stage 9
      s9_pw1  <= mul_lo64(s8_vv, {1'b0, p1});
      s9_pnum <= ({43'd0, p_delta} << 31) - s8_w2;
      s9_e4   <= asr32(s8_e4raw, 10) + 32'd2097152;
      s9_e1   <= s8_e1;
      s9_temp <= s8_temp;
      // stage 10: divisor and scaled dividend
      s10_den   <= s9_pw1[63:33];
      s10_numr  <= mul_lo64(s9_pnum, 17'd3125);
      s10_e5raw <= s9_e4 * h2_32 + 32'd8192;
      s10_e1    <= s9_e1;
      s10_temp  <= s9_temp;
    end
  end

  // --------------------------------------------------------------------------
  // divider, humidity terms and temperature ride along
  // --------------------------------------------------------------------------
  logic [NUM_W-1:0]  div_q;
  logic [SIDE_W-1:0] div_side;
  logic [31:0]       dv_temp, dv_e1, dv_e5raw;
  logic              dv_inv;

  src_div #(
    .SIDE_W(SIDE_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s_vld[10]),
    .numer    (s10_numr),
    .denom    (s10_den),
    .side_in  ({s10_temp, s10_e1, s10_e5raw, s10_den == '0}),
    .out_vld  (div_vld),
    .quot     (div_q),
    .side_out (div_side)
  );

  assign {dv_temp, dv_e1, dv_e5raw, dv_inv} = div_side;

  // --------------------------------------------------------------------------
  // back stages: pressure corrections, humidity tail and clamp
  // --------------------------------------------------------------------------
  logic [63:0] d1_q, d2_q, d3_q, d1_p8q, d2_ss, d2_w2p, d3_w2p, d3_w1p, d4_sum;
  logic [51:0] d1_pll;
  logic [51:0] d1_phl;
  logic [49:0] d1_phh;
  logic [31:0] d1_x2, d2_x2, d3_x2, d2_yy, d3_zh;
  logic [31:0] d1_temp, d2_temp, d3_temp, d4_temp, d5_temp;
  logic        d1_inv, d2_inv, d3_inv, d4_inv, d5_inv;
  logic [16:0] d4_hum, d5_hum;
  logic [31:0] d5_press;

  logic [25:0]        q_lo;
  logic [24:0]        q_hi;
  logic [51:0]        pll;
  logic signed [51:0] phl;
  logic signed [49:0] phh;
  logic signed [33:0] yy_full;
  logic [31:0]        x3;
  logic [16:0]        hum_clamp;

  // square of p >> 13 split into a 26-bit low and a 25-bit high part
  always_comb begin
    q_lo      = div_q[38:13];
    q_hi      = div_q[63:39];
    pll       = {26'd0, q_lo} * {26'd0, q_lo};
    phl       = $signed(q_hi) * $signed({1'b0, q_lo});
    phh       = $signed(q_hi) * $signed(q_hi);
    yy_full   = $signed(d1_x2[31:15]) * $signed(d1_x2[31:15]);
    x3        = d3_x2 - asr32(d3_zh, 4);
    if (x3[31]) begin
      hum_clamp = '0;
    end else if (x3 > HUM_CLAMP) begin
      hum_clamp = HUM_MAX;
    end else begin
      hum_clamp = x3[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // back stage 1
      d1_q    <= div_q;
      d1_pll  <= pll;
      d1_phl  <= phl;
      d1_phh  <= phh;
      d1_p8q  <= mul_lo64(div_q, {p8[15], p8});
      d1_x2   <= dv_e1 * asr32(dv_e5raw, 14);
      d1_temp <= dv_temp;
      d1_inv  <= dv_inv;
      // back stage 2
      d2_ss   <= {12'd0, d1_pll} + ({{12{d1_phl[51]}}, d1_phl} << 27)
                 + ({{14{d1_phh[49]}}, d1_phh} << 52);
      d2_w2p  <= asr64(d1_p8q, 19);
      d2_q    <= d1_q;
      d2_yy   <= yy_full[31:0];
      d2_x2   <= d1_x2;
      d2_temp <= d1_temp;
      d2_inv  <= d1_inv;
      // back stage 3
      d3_w1p  <= asr64(mul_lo64(d2_ss, {p9[15], p9}), 25);
      d3_w2p  <= d2_w2p;
      d3_q    <= d2_q;
      d3_zh   <= asr32(d2_yy, 7) * {24'd0, h1};
      d3_x2   <= d2_x2;
      d3_temp <= d2_temp;
      d3_inv  <= d2_inv;
      // back stage 4
      d4_sum  <= d3_q + d3_w1p + d3_w2p;
      d4_hum  <= hum_clamp;
      d4_temp <= d3_temp;
      d4_inv  <= d3_inv;
      // back stage 5: Q24.8 pressure, zero when the divisor was zero
      d5_press <= d4_inv ? 32'd0 : (d4_sum[39:8] + (p7_32 << 4));
      d5_hum   <= d4_hum;
      d5_temp  <= d4_temp;
      d5_inv   <= d4_inv;
    end
  end

  // --------------------------------------------------------------------------
  // result register with one skid entry
  // --------------------------------------------------------------------------
  logic [31:0] skid_temp, skid_press;
  logic        skid_inv;
  logic [16:0] skid_hum;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_vld     <= 1'b0;
    end else if (!result_valid || result_ready) begin
      if (skid_vld) begin
        result_valid <= 1'b1;
        skid_vld     <= 1'b0;
      end else begin
        result_valid <= d_vld[5];
      end
    end else if (d_vld[5] && adv) begin
      skid_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || result_ready) begin
      if (skid_vld) begin
        temperature_centi <= skid_temp;
        pressure_q24_8    <= skid_press;
        pressure_invalid  <= skid_inv;
        humidity_q22_10   <= skid_hum;
      end else begin
        temperature_centi <= d5_temp;
        pressure_q24_8    <= d5_press;
        pressure_invalid  <= d5_inv;
        humidity_q22_10   <= d5_hum;
      end
    end else if (adv) begin
      skid_temp  <= d5_temp;
      skid_press <= d5_press;
      skid_inv   <= d5_inv;
      skid_hum   <= d5_hum;
    end
  end

endmodule

// ===== sv/src_check.sv =====
// ----------------------------------------------------------------------------
// src_check
// Port-level checks on the result channel of the compensation block
// ----------------------------------------------------------------------------
`include "sensor_raw_compensation_assert.svh"

module src_check (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] temperature_centi,
  input logic [31:0] pressure_q24_8,
  input logic        pressure_invalid,
  input logic [16:0] humidity_q22_10
);

  // a stalled result stays and keeps its payload
  `SRC_ASSERT_NXT(a_hold_valid, result_valid && !result_ready, result_valid)
  `SRC_ASSERT_NXT(a_hold_data, result_valid && !result_ready, $stable(temperature_centi) && $stable(pressure_q24_8) && $stable(pressure_invalid) && $stable(humidity_q22_10))

  // zero divisor forces pressure to zero
  `SRC_ASSERT_IMP(a_invalid_zero, result_valid && pressure_invalid, pressure_q24_8 == 32'd0)

  // humidity clamp
  `SRC_ASSERT_IMP(a_hum_range, result_valid, humidity_q22_10 <= 17'd102400)

endmodule

bind sensor_raw_compensation src_check u_src_check (.*);
